@@ rtl/mmhf_pkg.sv @@
package mmhf_pkg;

  localparam int MAX_WIDTH_DEF = 1024;

  localparam int CFG_W_W    = 11;
  localparam int CFG_H_W    = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int ROW_W      = CFG_H_W;
  localparam int CH_W       = 8;
  localparam int PIX_W      = 4 * CH_W;
  localparam int NUM_CH     = 3;
  localparam int WIN_N      = 9;
  localparam int WIN_CENTER = 4;
  localparam int SUM_W      = 12;
  localparam int CNT_W      = 4;

  localparam int MIN_DIM   = 3;
  localparam int MIN_NEIGH = 3;

  localparam logic [CFG_W_W-1:0] WIDTH_RESET  = CFG_W_W'(256);
  localparam logic [CFG_H_W-1:0] HEIGHT_RESET = CFG_H_W'(256);
  localparam logic [CH_W-1:0]    ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic capture;
    logic norm;
    logic look;
    logic shift;
    logic take_line;
    logic pend_inc;
    logic sum;
    logic div_start;
    logic take_center;
    logic take_quot;
    logic emit;
    logic pend_dec;
  } cmd_t;

  typedef struct packed {
    logic drain;
    logic pend_zero;
    logic pend_full;
    logic fill;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

@@ rtl/mmhf_in_if.sv @@
interface mmhf_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [mmhf_pkg::CH_W-1:0] in_red;
  logic [mmhf_pkg::CH_W-1:0] in_green;
  logic [mmhf_pkg::CH_W-1:0] in_blue;
  logic [mmhf_pkg::CH_W-1:0] in_alpha;

  modport source (output valid, mode, in_red, in_green, in_blue, in_alpha, input ready);
  modport sink (input valid, mode, in_red, in_green, in_blue, in_alpha, output ready);
endinterface

@@ rtl/mmhf_out_if.sv @@
interface mmhf_out_if;
  logic                      valid;
  logic                      ready;
  logic [mmhf_pkg::CH_W-1:0] out_red;
  logic [mmhf_pkg::CH_W-1:0] out_green;
  logic [mmhf_pkg::CH_W-1:0] out_blue;
  logic [mmhf_pkg::CH_W-1:0] out_alpha;
  logic                      end_of_frame;

  modport source (output valid, out_red, out_green, out_blue, out_alpha, end_of_frame,
                  input ready);
  modport sink (input valid, out_red, out_green, out_blue, out_alpha, end_of_frame,
                output ready);
endinterface

@@ rtl/mmhf_cfg_if.sv @@
interface mmhf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [mmhf_pkg::CFG_IDX_W-1:0]  index;
  logic [mmhf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/masked_mean_hole_fill_3x3_top.sv @@
// a pixel that causes no result is captured, normalized, read from the line stores and shifted in
// a pixel with a result is also summed, divided when it is filled (radix-2 divider) and emitted;
// a drain transaction reads the line store and is emitted if any pixel is pending
// throughput: one item at a time, held back by output back-pressure and set by the line store
// read-modify-write and the divider; output register lets the next item start early
// reset: async active low, counters and window cleared, line stores not cleared
module masked_mean_hole_fill_3x3_top #(
  parameter int MAX_WIDTH = mmhf_pkg::MAX_WIDTH_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  mmhf_in_if.sink    in_chan,
  mmhf_out_if.source out_chan,
  mmhf_cfg_if.sink   cfg_chan
);

  mmhf_pkg::cmd_t                 cmd;
  mmhf_pkg::stat_t                stat;
  logic                           in_ready;
  logic [mmhf_pkg::PIX_W-1:0]     in_px;
  logic [mmhf_pkg::PIX_W-1:0]     out_px;
  logic                           out_valid;
  logic                           out_eof;

  assign cfg_chan.ready = 1'b1;
  assign in_chan.ready  = in_ready;
  assign in_px = {in_chan.in_alpha, in_chan.in_blue, in_chan.in_green, in_chan.in_red};

  mmhf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_chan.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mmhf_dp #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_chan.valid),
    .cfg_idx_i   (cfg_chan.index),
    .cfg_data_i  (cfg_chan.data),
    .mode_i      (in_chan.mode),
    .px_i        (in_px),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid),
    .out_ready_i (out_chan.ready),
    .out_px_o    (out_px),
    .out_eof_o   (out_eof)
  );

  assign out_chan.valid        = out_valid;
  assign out_chan.out_red      = out_px[7:0];
  assign out_chan.out_green    = out_px[15:8];
  assign out_chan.out_blue     = out_px[23:16];
  assign out_chan.out_alpha    = out_px[31:24];
  assign out_chan.end_of_frame = out_eof;

endmodule

@@ rtl/mmhf_ram.sv @@
module mmhf_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/mmhf_div.sv @@
module mmhf_div (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  start_i,
  input  logic [mmhf_pkg::NUM_CH-1:0][mmhf_pkg::SUM_W-1:0]       dividend_i,
  input  logic [mmhf_pkg::CNT_W-1:0]                             divisor_i,
  output logic                                                  busy_o,
  output logic [mmhf_pkg::NUM_CH-1:0][mmhf_pkg::SUM_W-1:0]       quot_o
);

  localparam int SW = mmhf_pkg::SUM_W;
  localparam int DW = mmhf_pkg::CNT_W;
  localparam int NC = mmhf_pkg::NUM_CH;
  localparam int CW = $clog2(SW + 1);

  logic [CW-1:0]           cnt_q, cnt_d;
  logic [NC-1:0][SW-1:0]   dvd_q, dvd_d;
  logic [NC-1:0][DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]           dvs_q, dvs_d;
  logic [NC-1:0][DW:0]     trial;
  logic [NC-1:0]           ge;

  // one quotient bit per channel each cycle, restoring
  always_comb begin
    cnt_d = cnt_q;
    dvd_d = dvd_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    for (int c = 0; c < NC; c++) begin
      trial[c] = {rem_q[c], dvd_q[c][SW-1]};
      ge[c]    = trial[c] >= {1'b0, dvs_q};
    end
    if (start_i) begin
      cnt_d = CW'(SW);
      dvd_d = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CW'(1);
      for (int c = 0; c < NC; c++) begin
        rem_d[c] = ge[c] ? DW'(trial[c] - {1'b0, dvs_q}) : trial[c][DW-1:0];
        dvd_d[c] = {dvd_q[c][SW-2:0], ge[c]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = cnt_q != '0;
  assign quot_o = dvd_q;

endmodule

@@ rtl/mmhf_ctrl.sv @@
module mmhf_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mmhf_pkg::stat_t stat_i,
  output mmhf_pkg::cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_NORM   = 8'b0000_0010,
    S_LOOK   = 8'b0000_0100,
    S_UPDATE = 8'b0000_1000,
    S_SUM    = 8'b0001_0000,
    S_CHK    = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_EMIT   = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_NORM;
        end
      end
      S_NORM: begin
        cmd_o.norm = 1'b1;
        state_d    = S_LOOK;
      end
      S_LOOK: begin
        if (stat_i.drain && stat_i.pend_zero) begin
          state_d = S_IDLE;
        end else begin
          cmd_o.look = 1'b1;
          state_d    = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (stat_i.drain) begin
          cmd_o.take_line = 1'b1;
          state_d         = S_EMIT;
        end else begin
          cmd_o.shift = 1'b1;
          if (stat_i.pend_full) begin
            state_d = S_SUM;
          end else begin
            cmd_o.pend_inc = 1'b1;
            state_d        = S_IDLE;
          end
        end
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_CHK;
      end
      S_CHK: begin
        if (stat_i.fill) begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end else begin
          cmd_o.take_center = 1'b1;
          state_d           = S_EMIT;
        end
      end
      S_DIV: begin
        if (!stat_i.div_busy) begin
          cmd_o.take_quot = 1'b1;
          state_d         = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit     = 1'b1;
          cmd_o.pend_dec = stat_i.drain;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/mmhf_dp.sv @@
module mmhf_dp #(
  parameter int MAX_WIDTH = mmhf_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mmhf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mmhf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              mode_i,
  input  logic [mmhf_pkg::PIX_W-1:0]        px_i,
  input  mmhf_pkg::cmd_t                    cmd_i,
  output mmhf_pkg::stat_t                   stat_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [mmhf_pkg::PIX_W-1:0]        out_px_o,
  output logic                              out_eof_o
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int EW  = (WW > mmhf_pkg::CFG_W_W) ? WW : mmhf_pkg::CFG_W_W;
  localparam int XW  = EW + 1;
  localparam int PW  = $clog2(MAX_WIDTH + 2);
  localparam int RW  = mmhf_pkg::ROW_W;
  localparam int PXW = mmhf_pkg::PIX_W;
  localparam int CHW = mmhf_pkg::CH_W;
  localparam int SW  = mmhf_pkg::SUM_W;
  localparam int NW  = mmhf_pkg::CNT_W;
  localparam int NC  = mmhf_pkg::NUM_CH;

  logic [mmhf_pkg::CFG_W_W-1:0] cfg_width_q;
  logic [mmhf_pkg::CFG_H_W-1:0] cfg_height_q;

  logic [EW-1:0] fw_x, eff_w;
  logic [RW-1:0] eff_h, h_m1, h_m2;
  logic [XW-1:0] w_x, w1_x, w2_x, w_m1, w_m2;

  logic [AW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d, row_t, row_nx;
  logic [PW-1:0] pend_q, pend_d;
  logic [XW-1:0] col_x, col_nx, sum_x, k_x;

  logic           mode_q;
  logic [PXW-1:0] px_q;
  logic [AW-1:0]  raddr, addr_q;
  logic [PXW-1:0] up_rd, mid_rd;

  logic [mmhf_pkg::WIN_N-1:0][PXW-1:0] win_q;
  logic [NC-1:0][SW-1:0]               acc, sum_q, quot;
  logic [NW-1:0]                       acc_cnt, cnt_q;
  logic                                interior, fill_q, div_busy;

  logic           out_valid_q;
  logic [PXW-1:0] out_px_q, res_q;
  logic           out_eof_q;
  logic           out_free, at_last;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= mmhf_pkg::WIDTH_RESET;
      cfg_height_q <= mmhf_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mmhf_pkg::REG_FRAME_WIDTH:  cfg_width_q  <= cfg_data_i[mmhf_pkg::CFG_W_W-1:0];
        mmhf_pkg::REG_FRAME_HEIGHT: cfg_height_q <= cfg_data_i[mmhf_pkg::CFG_H_W-1:0];
        default: ;
      endcase
    end
  end

  // clamped frame size
  always_comb begin
    fw_x = EW'(cfg_width_q);
    if (fw_x < EW'(mmhf_pkg::MIN_DIM)) begin
      eff_w = EW'(mmhf_pkg::MIN_DIM);
    end else if (fw_x > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = fw_x;
    end
    if (cfg_height_q < RW'(mmhf_pkg::MIN_DIM)) begin
      eff_h = RW'(mmhf_pkg::MIN_DIM);
    end else begin
      eff_h = cfg_height_q;
    end
  end

  assign w_x   = XW'(eff_w);
  assign w1_x  = w_x + XW'(1);
  assign w2_x  = {w_x[XW-2:0], 1'b0};
  assign w_m1  = w_x - XW'(1);
  assign w_m2  = w_x - XW'(2);
  assign h_m1  = eff_h - RW'(1);
  assign h_m2  = eff_h - RW'(2);
  assign col_x = XW'(col_q);

  // position and pending counters
  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    pend_d = pend_q;
    row_t  = row_q;
    row_nx = row_q + RW'(1);
    col_nx = col_x + XW'(1);
    if (cmd_i.norm) begin
      if (col_x >= w_x) begin
        col_d = '0;
        row_t = row_nx;
      end
      row_d = (row_t >= eff_h) ? '0 : row_t;
      if (XW'(pend_q) > w1_x) begin
        pend_d = PW'(w1_x);
      end
    end
    if (cmd_i.pend_inc) begin
      pend_d = pend_q + PW'(1);
    end
    if (cmd_i.pend_dec) begin
      pend_d = pend_q - PW'(1);
    end
    if (cmd_i.emit) begin
      if (col_nx >= w_x) begin
        col_d = '0;
        row_d = (row_nx >= eff_h) ? '0 : row_nx;
      end else begin
        col_d = col_nx[AW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= '0;
      mode_q <= 1'b0;
    end else begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
      if (cmd_i.capture) begin
        mode_q <= mode_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      px_q <= px_i;
    end
  end

  // line store address, oldest column plus pending modulo width, or the column itself in drain mode
  always_comb begin
    sum_x = col_x + XW'(pend_q);
    if (sum_x >= w2_x) begin
      k_x = sum_x - w2_x;
    end else if (sum_x >= w_x) begin
      k_x = sum_x - w_x;
    end else begin
      k_x = sum_x;
    end
    raddr = mode_q ? col_q : k_x[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.look) begin
      addr_q <= raddr;
    end
  end

  mmhf_ram #(
    .WIDTH (PXW),
    .DEPTH (MAX_WIDTH)
  ) u_upper (
    .clk_i   (clk_i),
    .we_i    (cmd_i.shift),
    .waddr_i (addr_q),
    .wdata_i (mid_rd),
    .re_i    (cmd_i.look),
    .raddr_i (raddr),
    .rdata_o (up_rd)
  );

  mmhf_ram #(
    .WIDTH (PXW),
    .DEPTH (MAX_WIDTH)
  ) u_middle (
    .clk_i   (clk_i),
    .we_i    (cmd_i.shift),
    .waddr_i (addr_q),
    .wdata_i (px_q),
    .re_i    (cmd_i.look),
    .raddr_i (raddr),
    .rdata_o (mid_rd)
  );

  // 3x3 window, right column comes from the line stores and the new pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (cmd_i.shift) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]   <= win_q[r*3+1];
        win_q[r*3+1] <= win_q[r*3+2];
      end
      win_q[2] <= up_rd;
      win_q[5] <= mid_rd;
      win_q[8] <= px_q;
    end
  end

  // masked sums over the window
  always_comb begin
    acc     = '0;
    acc_cnt = '0;
    for (int i = 0; i < mmhf_pkg::WIN_N; i++) begin
      if (win_q[i][PXW-1 -: CHW] != '0) begin
        for (int c = 0; c < NC; c++) begin
          acc[c] = acc[c] + SW'(win_q[i][c*CHW +: CHW]);
        end
        acc_cnt = acc_cnt + NW'(1);
      end
    end
    interior = (row_q >= RW'(1)) && (row_q <= h_m2) &&
               (col_x >= XW'(1)) && (col_x <= w_m2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 1'b0;
    end else if (cmd_i.sum) begin
      fill_q <= (win_q[mmhf_pkg::WIN_CENTER][PXW-1 -: CHW] == '0) && interior &&
                (acc_cnt >= NW'(mmhf_pkg::MIN_NEIGH));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      sum_q <= acc;
      cnt_q <= acc_cnt;
    end
  end

  mmhf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (sum_q),
    .divisor_i  (cnt_q),
    .busy_o     (div_busy),
    .quot_o     (quot)
  );

  // result pixel
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_line) begin
      res_q <= stat_o.pend_full ? up_rd : mid_rd;
    end else if (cmd_i.take_center) begin
      res_q <= win_q[mmhf_pkg::WIN_CENTER];
    end else if (cmd_i.take_quot) begin
      res_q <= {mmhf_pkg::ALPHA_OPAQUE, quot[2][CHW-1:0], quot[1][CHW-1:0],
                quot[0][CHW-1:0]};
    end
  end

  // output register
  assign out_free = !out_valid_q || out_ready_i;
  assign at_last  = (row_q == h_m1) && (col_x == w_m1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_px_q  <= res_q;
      out_eof_q <= at_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_px_o    = out_px_q;
  assign out_eof_o   = out_eof_q;

  assign stat_o.drain     = mode_q;
  assign stat_o.pend_zero = pend_q == '0;
  assign stat_o.pend_full = XW'(pend_q) >= w1_x;
  assign stat_o.fill      = fill_q;
  assign stat_o.div_busy  = div_busy;
  assign stat_o.out_free  = out_free;

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken transaction");

  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> (cnt_q >= NW'(mmhf_pkg::MIN_NEIGH)) && (cnt_q <= NW'(8)))
    else $error("fill started with bad neighbor count");

  a_norm_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.look |-> (XW'(pend_q) <= w1_x) && (col_x < w_x) && (row_q < eff_h))
    else $error("counters out of range after normalize");

  a_shift_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.shift || cmd_i.take_line) |-> $past(cmd_i.look))
    else $error("line store data used without a fresh read");

endmodule

@@ test/mmhf_stream_monitor.sv @@
`timescale 1ns / 100ps

module mmhf_stream_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  mmhf_in_if          in_mon,
  mmhf_out_if         out_mon,
  mmhf_cfg_if         cfg_mon,
  output int unsigned fail_count_o,
  output int unsigned open_count_o
);

  localparam int IDX_W = $clog2(mmhf_pkg::MAX_WIDTH_DEF);

  typedef struct packed {
    logic [mmhf_pkg::CH_W-1:0] red;
    logic [mmhf_pkg::CH_W-1:0] green;
    logic [mmhf_pkg::CH_W-1:0] blue;
    logic [mmhf_pkg::CH_W-1:0] alpha;
    logic                      eof;
  } out_pixel_t;

  out_pixel_t filled_stream[$];

  logic [mmhf_pkg::CFG_W_W-1:0] width_reg;
  logic [mmhf_pkg::CFG_H_W-1:0] height_reg;
  logic [mmhf_pkg::PIX_W-1:0]   line_above [mmhf_pkg::MAX_WIDTH_DEF];
  logic [mmhf_pkg::PIX_W-1:0]   line_mid [mmhf_pkg::MAX_WIDTH_DEF];
  logic [mmhf_pkg::PIX_W-1:0]   win [mmhf_pkg::WIN_N];
  int unsigned                  col_pos;
  int unsigned                  row_pos;
  int unsigned                  held_count;
  int unsigned                  mismatches;

  function automatic void queue_pixel(logic [mmhf_pkg::PIX_W-1:0] px, int unsigned w,
                                      int unsigned h);
    out_pixel_t item;
    item.red   = px[7:0];
    item.green = px[15:8];
    item.blue  = px[23:16];
    item.alpha = px[31:24];
    item.eof   = (row_pos == h - 1) && (col_pos == w - 1);
    filled_stream.insert(filled_stream.size(), item);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function automatic void hole_fill_step(logic drain, logic [mmhf_pkg::PIX_W-1:0] px);
    int unsigned                w, h, k, cnt, sr, sg, sb;
    logic [IDX_W-1:0]           a;
    logic [mmhf_pkg::PIX_W-1:0] above, mid, center;
    w = 32'(width_reg);
    if (w < mmhf_pkg::MIN_DIM) w = mmhf_pkg::MIN_DIM;
    if (w > mmhf_pkg::MAX_WIDTH_DEF) w = mmhf_pkg::MAX_WIDTH_DEF;
    h = 32'(height_reg);
    if (h < mmhf_pkg::MIN_DIM) h = mmhf_pkg::MIN_DIM;
    // a resize may leave the position or the backlog out of range
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
    end
    if (row_pos >= h) row_pos = 0;
    if (held_count > w + 1) held_count = w + 1;

    if (drain) begin
      if (held_count != 0) begin
        a = col_pos[IDX_W-1:0];
        center = (held_count >= w + 1) ? line_above[a] : line_mid[a];
        held_count--;
        queue_pixel(center, w, h);
      end
    end else begin
      k = (col_pos + held_count) % w;
      a = k[IDX_W-1:0];
      above = line_above[a];
      mid = line_mid[a];
      line_above[a] = mid;
      line_mid[a] = px;
      win[0] = win[1];
      win[1] = win[2];
      win[3] = win[4];
      win[4] = win[5];
      win[6] = win[7];
      win[7] = win[8];
      win[2] = above;
      win[5] = mid;
      win[8] = px;
      if (held_count < w + 1) begin
        held_count++;
      end else begin
        center = win[mmhf_pkg::WIN_CENTER];
        if (center[31:24] == 0 && row_pos >= 1 && row_pos <= h - 2 &&
            col_pos >= 1 && col_pos <= w - 2) begin
          cnt = 0;
          sr = 0;
          sg = 0;
          sb = 0;
          foreach (win[i]) begin
            if (win[i][31:24] != 0) begin
              sr += 32'(win[i][7:0]);
              sg += 32'(win[i][15:8]);
              sb += 32'(win[i][23:16]);
              cnt++;
            end
          end
          if (cnt >= mmhf_pkg::MIN_NEIGH) begin
            center = {mmhf_pkg::ALPHA_OPAQUE, 8'(sb / cnt), 8'(sg / cnt), 8'(sr / cnt)};
          end
        end
        queue_pixel(center, w, h);
      end
    end
  endfunction

  function automatic void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t mismatch on %s: expected %0d actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_pixel_t want, got;
    if (!rst_ni) begin
      width_reg = mmhf_pkg::WIDTH_RESET;
      height_reg = mmhf_pkg::HEIGHT_RESET;
      foreach (line_above[i]) begin
        line_above[i] = '0;
        line_mid[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      held_count = 0;
      mismatches = 0;
      filled_stream.delete();
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.index == mmhf_pkg::REG_FRAME_WIDTH) begin
          width_reg = cfg_mon.data[mmhf_pkg::CFG_W_W-1:0];
        end else if (cfg_mon.index == mmhf_pkg::REG_FRAME_HEIGHT) begin
          height_reg = cfg_mon.data[mmhf_pkg::CFG_H_W-1:0];
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.out_red, out_mon.out_green, out_mon.out_blue, out_mon.out_alpha,
               out_mon.end_of_frame};
        if (filled_stream.size() == 0) begin
          $display("%0t unexpected pixel: expected none actual %h", $time, got);
          mismatches++;
        end else begin
          want = filled_stream.pop_front();
          compare_field("red", 32'(want.red), 32'(got.red));
          compare_field("green", 32'(want.green), 32'(got.green));
          compare_field("blue", 32'(want.blue), 32'(got.blue));
          compare_field("alpha", 32'(want.alpha), 32'(got.alpha));
          compare_field("end_of_frame", 32'(want.eof), 32'(got.eof));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        hole_fill_step(in_mon.mode,
                       {in_mon.in_alpha, in_mon.in_blue, in_mon.in_green, in_mon.in_red});
      end
    end
    fail_count_o <= mismatches;
    open_count_o <= filled_stream.size();
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int CHW    = mmhf_pkg::CH_W;
  localparam int CFG_DW = mmhf_pkg::CFG_DATA_W;

  typedef enum int {
    SINK_OPEN,
    SINK_LIGHT,
    SINK_HEAVY,
    SINK_PERIODIC
  } sink_pace_e;

  logic clk_i;
  logic rst_ni;

  mmhf_in_if  in_chan ();
  mmhf_out_if out_chan ();
  mmhf_cfg_if cfg_chan ();

  int unsigned fail_count;
  int unsigned open_count;
  int unsigned burst_left;
  int unsigned frame_w;
  int unsigned frame_h;
  int unsigned pixels_sent;

  // two 3x3 frames: a fill from seven neighbors, then a hole released by drain
  logic [mmhf_pkg::PIX_W-1:0] seed_frames [18] = '{
    32'hFFFFFFFF, 32'h01000000, 32'h808000FF,
    32'h00030201, 32'h00635854, 32'hC81E140A,
    32'hFF00FFFF, 32'h40070503, 32'h027F01FE,
    32'h10203040, 32'h00AABBCC, 32'h7F112233,
    32'h00FFFFFF, 32'h00010203, 32'h00445566,
    32'h00778899, 32'h00000000, 32'hFE0C0B0A
  };

  masked_mean_hole_fill_3x3_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  mmhf_stream_monitor u_mon (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_chan),
    .out_mon      (out_chan),
    .cfg_mon      (cfg_chan),
    .fail_count_o (fail_count),
    .open_count_o (open_count)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // output backpressure
  initial begin
    sink_pace_e  sink_pace;
    int unsigned pace_left;
    sink_pace = SINK_OPEN;
    pace_left = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (pace_left == 0) begin
        sink_pace = sink_pace_e'($urandom_range(0, 3));
        pace_left = $urandom_range(30, 300);
      end else begin
        pace_left--;
      end
      case (sink_pace)
        SINK_OPEN:  out_chan.ready <= 1'b1;
        SINK_LIGHT: out_chan.ready <= ($urandom_range(0, 3) != 0);
        SINK_HEAVY: out_chan.ready <= ($urandom_range(0, 2) == 0);
        default:    out_chan.ready <= (pace_left % 6 < 4);
      endcase
    end
  end

  function automatic logic [mmhf_pkg::PIX_W-1:0] random_pixel(int unsigned hole_pct);
    logic [CHW-1:0] ch [3];
    logic [CHW-1:0] alpha;
    foreach (ch[i]) begin
      if ($urandom_range(0, 7) == 0) ch[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      else ch[i] = CHW'($urandom_range(0, 255));
    end
    if ($urandom_range(0, 99) < hole_pct) alpha = 8'h00;
    else if ($urandom_range(0, 7) == 0) alpha = 8'hFF;
    else alpha = CHW'($urandom_range(1, 255));
    return {alpha, ch[2], ch[1], ch[0]};
  endfunction

  task automatic offer_item(logic drain, logic [mmhf_pkg::PIX_W-1:0] px);
    int unsigned gap;
    in_chan.valid    <= 1'b1;
    in_chan.mode     <= drain;
    in_chan.in_red   <= px[7:0];
    in_chan.in_green <= px[15:8];
    in_chan.in_blue  <= px[23:16];
    in_chan.in_alpha <= px[31:24];
    @(posedge clk_i);
    while (!in_chan.ready) @(posedge clk_i);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 20);
    end
  endtask

  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk_i);
    while (open_count != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(mmhf_pkg::cfg_reg_e idx, logic [CFG_DW-1:0] value);
    int unsigned w;
    settle();
    // a pixel with no output may still be in flight
    repeat (30) @(posedge clk_i);
    cfg_chan.valid <= 1'b1;
    cfg_chan.index <= idx;
    cfg_chan.data  <= value;
    @(posedge clk_i);
    while (!cfg_chan.ready) @(posedge clk_i);
    cfg_chan.valid <= 1'b0;
    if (idx == mmhf_pkg::REG_FRAME_WIDTH) begin
      w = 32'(value[mmhf_pkg::CFG_W_W-1:0]);
      frame_w = (w < mmhf_pkg::MIN_DIM) ? mmhf_pkg::MIN_DIM :
                ((w > mmhf_pkg::MAX_WIDTH_DEF) ? mmhf_pkg::MAX_WIDTH_DEF : w);
    end else begin
      w = 32'(value);
      frame_h = (w < mmhf_pkg::MIN_DIM) ? mmhf_pkg::MIN_DIM : w;
    end
  endtask

  // whole frames, with extra drains when stirred, then a drain of the tail
  task automatic stream_phase(int unsigned frames, int unsigned hole_pct, bit stir);
    int unsigned f, p, pause_at;
    pause_at = $urandom_range(0, frame_w * frame_h - 1);
    if (stir) repeat ($urandom_range(0, 2)) offer_item(1'b1, $urandom());
    for (f = 0; f < frames; f++) begin
      for (p = 0; p < frame_w * frame_h; p++) begin
        if (stir && f == 0 && p == pause_at) settle();
        // partial drains only once the line stores hold this frame size
        if (stir && f > 0 && $urandom_range(0, 99) < 3) begin
          repeat ($urandom_range(1, 4)) offer_item(1'b1, $urandom());
        end
        offer_item(1'b0, random_pixel(hole_pct));
        if (stir) pixels_sent++;
      end
    end
    repeat (frame_w + 1 + $urandom_range(0, 2)) offer_item(1'b1, $urandom());
  endtask

  initial begin
    logic [4:0] i;
    rst_ni           <= 1'b0;
    in_chan.valid    <= 1'b0;
    in_chan.mode     <= 1'b0;
    in_chan.in_red   <= '0;
    in_chan.in_green <= '0;
    in_chan.in_blue  <= '0;
    in_chan.in_alpha <= '0;
    cfg_chan.valid   <= 1'b0;
    cfg_chan.index   <= mmhf_pkg::REG_FRAME_WIDTH;
    cfg_chan.data    <= '0;
    burst_left = 1;
    pixels_sent = 0;
    frame_w = 32'(mmhf_pkg::WIDTH_RESET);
    frame_h = 32'(mmhf_pkg::HEIGHT_RESET);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(mmhf_pkg::REG_FRAME_WIDTH, 12'd3);
    write_reg(mmhf_pkg::REG_FRAME_HEIGHT, 12'd3);
    offer_item(1'b1, '1);
    for (i = 5'd0; i < 5'd15; i++) offer_item(1'b0, seed_frames[i]);
    repeat (3) offer_item(1'b1, $urandom());
    for (i = 5'd15; i < 5'd18; i++) offer_item(1'b0, seed_frames[i]);
    repeat (5) offer_item(1'b1, $urandom());

    // sizes below range act as the minimum
    write_reg(mmhf_pkg::REG_FRAME_WIDTH, 12'd2);
    write_reg(mmhf_pkg::REG_FRAME_HEIGHT, 12'd0);
    stream_phase(1, 40, 1'b0);

    while (pixels_sent < 500) begin
      write_reg(mmhf_pkg::REG_FRAME_WIDTH,
                CFG_DW'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                    : $urandom_range(3, 16)));
      write_reg(mmhf_pkg::REG_FRAME_HEIGHT,
                CFG_DW'(($urandom_range(0, 5) == 0) ? $urandom_range(0, 2)
                                                    : $urandom_range(3, 10)));
      stream_phase($urandom_range(1, 3), $urandom_range(10, 70), 1'b1);
    end

    settle();
    repeat (30) @(posedge clk_i);
    if (fail_count == 0 && open_count == 0) begin
      $display("[masked_mean_hole_fill_3x3_top] OK");
    end else begin
      $display("[masked_mean_hole_fill_3x3_top] ERROR");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("[masked_mean_hole_fill_3x3_top] ERROR");
    $finish;
  end

endmodule

@@ files.f @@
rtl/mmhf_pkg.sv
rtl/mmhf_in_if.sv
rtl/mmhf_out_if.sv
rtl/mmhf_cfg_if.sv
rtl/mmhf_ram.sv
rtl/mmhf_div.sv
rtl/mmhf_ctrl.sv
rtl/mmhf_dp.sv
rtl/masked_mean_hole_fill_3x3_top.sv
test/mmhf_stream_monitor.sv
test/testbench.sv
